// File: rtl/tsne_pkg.sv
// ----------------------------------------------------------------------------
// tsne_pkg: shared types and constants of the exact t-SNE gradient unit
// Payload structs, mode codes and store geometry.
// ----------------------------------------------------------------------------
package tsne_pkg;

  localparam int unsigned MaxPoints = 16;
  localparam int unsigned MaxDims   = 4;
  localparam int unsigned PtW       = $clog2(MaxPoints);
  localparam int unsigned DimW      = $clog2(MaxDims);

  localparam logic [1:0] ModeLoadCoord = 2'd0;
  localparam logic [1:0] ModeLoadProb  = 2'd1;
  localparam logic [1:0] ModeCompute   = 2'd2;
  localparam logic [1:0] ModeReserved  = 2'd3;

  localparam logic [0:0] CfgNumPoints = 1'b0;
  localparam logic [0:0] CfgNumDims   = 1'b1;

  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [31:0] coord_value;
    logic [15:0]        prob_value;
  } tsne_in_t;

  typedef struct packed {
    logic [3:0]         grad_point;
    logic [1:0]         grad_dim;
    logic signed [47:0] grad_value;
    logic               status;
    logic               last;
  } tsne_out_t;

  // Divider request and response between the sequencer and the divider.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [48:0] den;
  } tsne_div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } tsne_div_rsp_t;

endpackage

// File: rtl/tsne_divider.sv
// ----------------------------------------------------------------------------
// tsne_divider: shared restoring divider
// Unsigned 64 by 49 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsne_divider (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tsne_pkg::tsne_div_req_t req_i,
  output tsne_pkg::tsne_div_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] quo_q, quo_d;
  logic [49:0] rem_q, rem_d;
  logic [48:0] den_q, den_d;
  logic        done_q, done_d;
  logic [49:0] trial;
  logic [49:0] shifted;

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    done_d  = 1'b0;
    shifted = {rem_q[48:0], quo_q[63]};
    trial   = shifted - {1'b0, den_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 7'd0;
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      if (!trial[49]) begin
        rem_d = trial;
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

  busy_start_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q) else $error("divider did not start");
  done_end_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  cnt_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |=> !busy_q || cnt_q == 7'd0) else $error("divider count not cleared");

endmodule

// File: rtl/tsne_exact_gradient_unit.sv
// ----------------------------------------------------------------------------
// tsne_exact_gradient_unit: exact t-SNE gradient, fixed point
// A load transaction writes its store directly. A compute transaction first
// sums the affinity mass. Each of the n*(n-1)/2 point pairs then gets its
// squared distance, one dimension at a time, and its kernel q on the one
// shared divider. Each point, dimension and neighbor then takes two
// divisions (q and q/q_sum), and each result is then emitted. Results are
// shown for one cycle each with done_o; the receiver cannot stall. busy is
// high while a compute transaction runs.
// ----------------------------------------------------------------------------
module tsne_exact_gradient_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  tsne_pkg::tsne_in_t   in_i,
  output logic                 done_o,
  output tsne_pkg::tsne_out_t  out_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [4:0]           cfg_data_i
);

  typedef enum logic [3:0] {
    StIdle, StMass, StMassChk, StDist, StDistWr, StQDiv, StQWait,
    StGradQ, StGradQWait, StGradN, StGradNWait, StGradAcc, StEmit
  } state_e;

  state_e state_q;
  logic [4:0] npts_q;
  logic [2:0] ndim_q;
  logic [3:0] n_m1, i_q, j_q;
  logic [1:0] d_m1, k_q;
  logic [4:0] n_c;
  logic [2:0] d_c;

  logic [31:0] coord_mem [tsne_pkg::MaxPoints*tsne_pkg::MaxDims];
  logic [15:0] prob_mem  [tsne_pkg::MaxPoints*tsne_pkg::MaxPoints];
  logic [47:0] sd_mem    [tsne_pkg::MaxPoints*tsne_pkg::MaxPoints];

  logic [31:0] ci_q, cj_q;
  logic [15:0] p_q;
  logic [47:0] sd_q;
  logic [47:0] sdacc_q;
  logic [23:0] mass_q;
  logic [47:0] qsum_q;
  logic [32:0] q_q;
  logic [33:0] t1_q;
  logic signed [51:0] acc_q;
  logic        rd_ok_q;
  logic        done_q;
  tsne_pkg::tsne_out_t out_q;

  tsne_pkg::tsne_div_req_t dreq;
  tsne_pkg::tsne_div_rsp_t drsp;

  tsne_divider u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  always_comb begin
    n_c = npts_q;
    if (npts_q < 5'd2) n_c = 5'd2;
    if (npts_q > 5'd16) n_c = 5'd16;
    d_c = ndim_q;
    if (ndim_q < 3'd1) d_c = 3'd1;
    if (ndim_q > 3'd4) d_c = 3'd4;
    n_m1 = 4'(n_c - 5'd1);
    d_m1 = 2'(d_c - 3'd1);
  end

  // Addresses follow the loop counters; read data is registered, so it arrives in the following cycle.
  logic [7:0] pair_ij, pair_lo;
  assign pair_ij = {i_q, j_q};
  assign pair_lo = (i_q < j_q) ? {i_q, j_q} : {j_q, i_q};

  always_ff @(posedge clk_i) begin
    ci_q <= coord_mem[{i_q, k_q}];
    cj_q <= coord_mem[{j_q, k_q}];
    p_q  <= prob_mem[pair_ij];
    sd_q <= sd_mem[pair_lo];
    if (start && !busy && in_i.mode == tsne_pkg::ModeLoadCoord && in_i.col_index < 4'd4)
      coord_mem[{in_i.row_index, in_i.col_index[1:0]}] <= in_i.coord_value;
    if (start && !busy && in_i.mode == tsne_pkg::ModeLoadProb)
      prob_mem[{in_i.row_index, in_i.col_index}] <= in_i.prob_value;
    if (state_q == StDistWr)
      sd_mem[pair_ij] <= sdacc_q;
  end

  // Arithmetic on registered operands.
  logic signed [32:0] delta;
  logic [32:0] dmag;
  logic [65:0] dsq;
  logic [48:0] sdsum;
  logic [65:0] t1full;
  logic [33:0] t1;
  logic signed [31:0] diff;
  logic [31:0] dfmag;
  logic [64:0] tfull;
  logic [51:0] term;
  logic        neg;
  logic [47:0] qn;

  always_comb begin
    delta  = 33'(signed'(ci_q)) - 33'(signed'(cj_q));
    dmag   = delta[32] ? 33'(-delta) : 33'(delta);
    dsq    = 66'(dmag) * 66'(dmag);
    sdsum  = 49'(sdacc_q) + 49'(dsq >> 16);
    t1full = 66'(dmag) * 66'(q_q);
    t1     = t1full[65:32];
    qn     = (qsum_q == '0) ? 48'd0 : 48'(drsp.quo);
    diff   = 32'({p_q, 14'd0}) - 32'(qn);
    dfmag  = diff[31] ? 32'(-diff) : 32'(diff);
    tfull  = 65'(t1_q) * 65'(dfmag[30:0]);
    term   = 52'(tfull >> 20);
    neg    = diff[31] ^ delta[32];
  end

  always_comb begin
    dreq = '0;
    if (state_q == StQDiv || state_q == StGradQ) begin
      dreq.start = 1'b1;
      dreq.num   = 64'd1 << 48;
      dreq.den   = 49'd65536 + 49'(sd_q);
    end else if (state_q == StGradN) begin
      dreq.start = 1'b1;
      dreq.num   = 64'(q_q) << 30;
      dreq.den   = (qsum_q == '0) ? 49'd1 : 49'(qsum_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      npts_q  <= 5'd16;
      ndim_q  <= 3'd2;
      i_q <= '0; j_q <= '0; k_q <= '0;
      mass_q <= '0; qsum_q <= '0; sdacc_q <= '0; q_q <= '0; acc_q <= '0;
      t1_q <= '0;
      rd_ok_q <= 1'b0;
      done_q <= 1'b0;
      out_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i && cfg_idx_i == tsne_pkg::CfgNumPoints) npts_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == tsne_pkg::CfgNumDims) ndim_q <= cfg_data_i[2:0];
      case (state_q)
        StIdle: begin
          if (start && in_i.mode == tsne_pkg::ModeCompute) begin
            i_q <= '0; j_q <= '0; k_q <= '0; mass_q <= '0; rd_ok_q <= 1'b0;
            state_q <= StMass;
          end
        end
        StMass: begin
          if (rd_ok_q) mass_q <= mass_q + 24'(p_q);
          rd_ok_q <= (i_q != j_q);
          if (j_q == n_m1) begin
            j_q <= '0;
            if (i_q == n_m1) state_q <= StMassChk;
            else i_q <= i_q + 4'd1;
          end else j_q <= j_q + 4'd1;
        end
        StMassChk: begin
          if (mass_q + (rd_ok_q ? 24'(p_q) : 24'd0) == '0) begin
            out_q <= '{grad_point: 4'd0, grad_dim: 2'd0, grad_value: '0,
                       status: 1'b1, last: 1'b1};
            done_q <= 1'b1;
            state_q <= StIdle;
          end else begin
            i_q <= '0; j_q <= 4'd1; k_q <= '0; sdacc_q <= '0; rd_ok_q <= 1'b0;
            state_q <= StDist;
          end
        end
        StDist: begin
          // Each dimension waits for its registered read, then adds its squared difference.
          if (!rd_ok_q) rd_ok_q <= 1'b1;
          else begin
            sdacc_q <= sdsum[48] ? 48'hFFFF_FFFF_FFFF : sdsum[47:0];
            rd_ok_q <= 1'b0;
            if (k_q == d_m1) state_q <= StDistWr;
            else k_q <= k_q + 2'd1;
          end
        end
        StDistWr: begin
          sdacc_q <= '0; k_q <= '0;
          if (j_q == n_m1) begin
            if (i_q == n_m1 - 4'd1) begin
              i_q <= '0; j_q <= 4'd1; qsum_q <= '0; rd_ok_q <= 1'b0;
              state_q <= StQDiv;
            end else begin
              i_q <= i_q + 4'd1; j_q <= i_q + 4'd2; state_q <= StDist;
            end
          end else begin
            j_q <= j_q + 4'd1; state_q <= StDist;
          end
        end
        StQDiv: begin
          if (!rd_ok_q) rd_ok_q <= 1'b1;
          else state_q <= StQWait;
        end
        StQWait: begin
          if (drsp.done) begin
            qsum_q <= qsum_q + {drsp.quo[46:0], 1'b0};
            rd_ok_q <= 1'b0;
            if (j_q == n_m1) begin
              if (i_q == n_m1 - 4'd1) begin
                i_q <= '0; j_q <= 4'd1; k_q <= '0; acc_q <= '0;
                state_q <= StGradQ;
              end else begin
                i_q <= i_q + 4'd1; j_q <= i_q + 4'd2; state_q <= StQDiv;
              end
            end else begin
              j_q <= j_q + 4'd1; state_q <= StQDiv;
            end
          end
        end
        StGradQ: begin
          if (!rd_ok_q) rd_ok_q <= 1'b1;
          else state_q <= StGradQWait;
        end
        StGradQWait: begin
          if (drsp.done) begin
            q_q <= drsp.quo[32:0];
            state_q <= StGradN;
          end
        end
        StGradN: state_q <= StGradNWait;
        StGradNWait: begin
          t1_q <= t1;
          if (drsp.done) state_q <= StGradAcc;
        end
        StGradAcc: begin
          logic signed [51:0] nacc;
          logic [3:0] nj;
          nacc = neg ? acc_q - signed'(term) : acc_q + signed'(term);
          nj = j_q + 4'd1;
          if (nj == i_q) nj = nj + 4'd1;
          rd_ok_q <= 1'b0;
          if (j_q == n_m1 || (j_q == n_m1 - 4'd1 && i_q == n_m1)) begin
            acc_q <= nacc;
            state_q <= StEmit;
          end else begin
            acc_q <= nacc; j_q <= nj; state_q <= StGradQ;
          end
        end
        StEmit: begin
          logic signed [47:0] sat;
          if (acc_q > 52'sd140737488355327) sat = 48'sh7FFF_FFFF_FFFF;
          else if (acc_q < -52'sd140737488355328) sat = 48'sh8000_0000_0000;
          else sat = acc_q[47:0];
          out_q <= '{grad_point: i_q, grad_dim: k_q, grad_value: sat, status: 1'b0,
                     last: (i_q == n_m1 && k_q == d_m1)};
          done_q <= 1'b1;
          acc_q <= '0;
          rd_ok_q <= 1'b0;
          if (k_q == d_m1) begin
            k_q <= '0;
            j_q <= 4'd0;
            if (i_q == n_m1) state_q <= StIdle;
            else begin
              i_q <= i_q + 4'd1; state_q <= StGradQ;
            end
          end else begin
            j_q <= (i_q == 4'd0) ? 4'd1 : 4'd0;
            k_q <= k_q + 2'd1; state_q <= StGradQ;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy   = (state_q != StIdle);
  assign done_o = done_q;
  assign out_o  = out_q;

  last_idle_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && out_q.last |-> state_q == StIdle) else $error("last result before idle");
  status_last_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && out_q.status |-> out_q.last) else $error("error result not last");
  j_ne_i_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StGradAcc |-> j_q != i_q) else $error("self pair in gradient");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for tsne_exact_gradient_unit
// The affinity and coordinate stores are filled first, then a table of
// directed transactions is walked: the zero-mass error, extreme coordinates
// that drive every pairwise kernel to zero, clamped register values and
// ignored loads. Random phases with fresh register settings follow. Every
// result is checked against a bit-exact gradient predictor kept in the bench.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct {
    bit                 is_cfg;
    logic               cfg_idx;
    logic [4:0]         cfg_data;
    tsne_pkg::tsne_in_t item;
    bit                 err_typed;
  } step_t;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  tsne_pkg::tsne_in_t  in_i;
  logic      done_o;
  tsne_pkg::tsne_out_t out_o;
  logic      cfg_we_i;
  logic      cfg_idx_i;
  logic [4:0] cfg_data_i;

  logic [31:0] coord_mem [tsne_pkg::MaxPoints*tsne_pkg::MaxDims];
  logic [15:0] prob_mem [tsne_pkg::MaxPoints*tsne_pkg::MaxPoints];
  logic [4:0]  np_reg;
  logic [2:0]  nd_reg;

  tsne_pkg::tsne_out_t grad_q[$];
  int        n_errors;
  int        n_items;
  int        n_computes;
  int        n_results;
  int        stall_cycles;
  step_t     steps[$];

  tsne_exact_gradient_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .done_o     (done_o),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [63:0] kernel_q(logic [63:0] sd);
    return (64'd1 << 48) / (64'd65536 + sd);
  endfunction

  function automatic longint coord_of(int p, int k);
    longint v;
    v = longint'($signed(coord_mem[p*tsne_pkg::MaxDims+k]));
    return v;
  endfunction

  function automatic void predict_gradient(input tsne_pkg::tsne_in_t it,
                                           ref tsne_pkg::tsne_out_t res[$]);
    int          n;
    int          d;
    logic [63:0] mass;
    logic [63:0] sd;
    logic [63:0] m;
    logic [63:0] sqd_tab [tsne_pkg::MaxPoints*tsne_pkg::MaxPoints];
    logic [63:0] qsum;
    logic [63:0] q;
    logic [63:0] qn;
    logic [63:0] t1;
    logic [63:0] t;
    longint      diff;
    longint      delta;
    longint      acc;
    tsne_pkg::tsne_out_t r;
    res = {};
    case (it.mode)
      tsne_pkg::ModeLoadCoord: begin
        if (it.col_index < tsne_pkg::MaxDims)
          coord_mem[it.row_index*tsne_pkg::MaxDims+it.col_index] = it.coord_value;
      end
      tsne_pkg::ModeLoadProb: begin
        prob_mem[it.row_index*tsne_pkg::MaxPoints+it.col_index] = it.prob_value;
      end
      tsne_pkg::ModeCompute: begin
        n = np_reg < 2 ? 2 : (np_reg > tsne_pkg::MaxPoints ? tsne_pkg::MaxPoints
                                                            : int'(np_reg));
        d = nd_reg < 1 ? 1 : (nd_reg > tsne_pkg::MaxDims ? tsne_pkg::MaxDims : int'(nd_reg));
        mass = 0;
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n; j++)
            if (i != j) mass += prob_mem[i*tsne_pkg::MaxPoints+j];
        if (mass == 0) begin
          r = '0;
          r.status = 1'b1;
          r.last = 1'b1;
          res.push_back(r);
          return;
        end
        for (int i = 0; i < n; i++)
          for (int j = i + 1; j < n; j++) begin
            sd = 0;
            for (int k = 0; k < d; k++) begin
              delta = coord_of(i, k) - coord_of(j, k);
              m = delta < 0 ? -delta : delta;
              sd += (m * m) >> 16;
              if (sd > 64'hFFFF_FFFF_FFFF) sd = 64'hFFFF_FFFF_FFFF;
            end
            sqd_tab[i*tsne_pkg::MaxPoints+j] = sd;
            sqd_tab[j*tsne_pkg::MaxPoints+i] = sd;
          end
        qsum = 0;
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n; j++)
            if (i != j) qsum += kernel_q(sqd_tab[i*tsne_pkg::MaxPoints+j]);
        for (int i = 0; i < n; i++)
          for (int k = 0; k < d; k++) begin
            acc = 0;
            for (int j = 0; j < n; j++) begin
              if (j == i) continue;
              q = kernel_q(sqd_tab[i*tsne_pkg::MaxPoints+j]);
              qn = qsum != 0 ? (q << 30) / qsum : 64'd0;
              diff = (longint'(prob_mem[i*tsne_pkg::MaxPoints+j]) <<< 14) - longint'(qn);
              delta = coord_of(i, k) - coord_of(j, k);
              m = delta < 0 ? -delta : delta;
              t1 = (m * q) >> 32;
              m = diff < 0 ? -diff : diff;
              t = (t1 * m) >> 20;
              acc += ((diff < 0) != (delta < 0)) ? -longint'(t) : longint'(t);
            end
            if (acc > 64'sd140737488355327) acc = 64'sd140737488355327;
            if (acc < -64'sd140737488355328) acc = -64'sd140737488355328;
            r.grad_point = i[3:0];
            r.grad_dim = k[1:0];
            r.grad_value = acc[47:0];
            r.status = 1'b0;
            r.last = (i == n - 1) && (k == d - 1);
            res.push_back(r);
          end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i) begin
    tsne_pkg::tsne_out_t want;
    stall_cycles++;
    if (done_o) begin
      stall_cycles = 0;
      n_results++;
      if (grad_q.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, out_o);
        n_errors++;
      end else begin
        want = grad_q.pop_front();
        if (out_o.grad_point !== want.grad_point || out_o.grad_dim !== want.grad_dim ||
            out_o.grad_value !== want.grad_value || out_o.status !== want.status ||
            out_o.last !== want.last) begin
          $display("%0t: mismatch, expected %p, actual %p", $time, want, out_o);
          n_errors++;
        end
      end
    end
    if (stall_cycles > 400000) begin
      $display("%0t: timeout waiting for a transaction", $time);
      $display("FAIL");
      $finish;
    end
  end

  task automatic wait_idle();
    while (grad_q.size() != 0 || busy) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [4:0] value);
    wait_idle();
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == tsne_pkg::CfgNumPoints) np_reg = value;
    else nd_reg = value[2:0];
  endtask

  task automatic send_item(input tsne_pkg::tsne_in_t it, input bit err_typed,
                           input bit idle_ok);
    tsne_pkg::tsne_out_t res[$];
    tsne_pkg::tsne_out_t err;
    bit        taken;
    if (idle_ok)
      while ($urandom_range(99) < 22) begin
        start = 1'b0;
        @(negedge clk_i);
      end
    start = 1'b1;
    in_i = it;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy;
      if (!taken) @(negedge clk_i);
    end
    stall_cycles = 0;
    n_items++;
    predict_gradient(it, res);
    if (it.mode == tsne_pkg::ModeCompute) n_computes++;
    if (err_typed) begin
      err = '0;
      err.status = 1'b1;
      err.last = 1'b1;
      grad_q.push_back(err);
    end else begin
      foreach (res[x]) grad_q.push_back(res[x]);
    end
    @(negedge clk_i);
    start = 1'b0;
  endtask

  function automatic tsne_pkg::tsne_in_t mk(logic [1:0] mode, int row, int col,
                                            logic [31:0] cv, logic [15:0] pv);
    tsne_pkg::tsne_in_t it;
    it.mode = mode;
    it.row_index = row[3:0];
    it.col_index = col[3:0];
    it.coord_value = cv;
    it.prob_value = pv;
    return it;
  endfunction

  function automatic step_t cfg_step(logic idx, logic [4:0] value);
    step_t s;
    s.is_cfg = 1'b1;
    s.cfg_idx = idx;
    s.cfg_data = value;
    s.item = '0;
    s.err_typed = 1'b0;
    return s;
  endfunction

  function automatic step_t item_step(tsne_pkg::tsne_in_t it, bit err_typed);
    step_t s;
    s.is_cfg = 1'b0;
    s.cfg_idx = 1'b0;
    s.cfg_data = '0;
    s.item = it;
    s.err_typed = err_typed;
    return s;
  endfunction

  function automatic tsne_pkg::tsne_in_t random_item(int kind);
    tsne_pkg::tsne_in_t it;
    it.mode = 2'($urandom_range(3));
    it.row_index = 4'($urandom_range(15));
    it.col_index = 4'($urandom_range(15));
    it.coord_value = $urandom;
    it.prob_value = 16'($urandom);
    if (kind < 45) begin
      it.mode = tsne_pkg::ModeLoadCoord;
      if ($urandom_range(9) != 0) it.col_index = 4'($urandom_range(tsne_pkg::MaxDims - 1));
    end else if (kind < 85) begin
      it.mode = tsne_pkg::ModeLoadProb;
      if ($urandom_range(99) < 15) it.prob_value = '0;
    end else if (kind < 95) begin
      it.mode = tsne_pkg::ModeCompute;
    end else begin
      it.mode = tsne_pkg::ModeReserved;
    end
    return it;
  endfunction

  initial begin
    logic [4:0] np_val;
    start = 1'b0;
    in_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = 1'b0;
    cfg_data_i = '0;
    n_errors = 0;
    n_items = 0;
    n_computes = 0;
    n_results = 0;
    stall_cycles = 0;
    np_reg = 5'd16;
    nd_reg = 3'd2;
    foreach (coord_mem[x]) coord_mem[x] = '0;
    foreach (prob_mem[x]) prob_mem[x] = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < tsne_pkg::MaxPoints; r++)
      for (int c = 0; c < tsne_pkg::MaxPoints; c++)
        send_item(mk(tsne_pkg::ModeLoadProb, r, c, $urandom, 16'($urandom)), 1'b0, 1'b1);
    for (int p = 0; p < tsne_pkg::MaxPoints; p++)
      for (int k = 0; k < tsne_pkg::MaxDims; k++)
        send_item(mk(tsne_pkg::ModeLoadCoord, p, k, $urandom, 16'($urandom)), 1'b0, 1'b1);

    steps.push_back(cfg_step(tsne_pkg::CfgNumPoints, 5'd2));
    steps.push_back(cfg_step(tsne_pkg::CfgNumDims, 5'd2));
    steps.push_back(item_step(mk(tsne_pkg::ModeLoadProb, 0, 1, '0, 16'h0000), 1'b0));
    steps.push_back(item_step(mk(tsne_pkg::ModeLoadProb, 1, 0, '0, 16'h0000), 1'b0));
    steps.push_back(item_step(mk(tsne_pkg::ModeCompute, 0, 0, '0, '0), 1'b1));
    steps.push_back(item_step(mk(tsne_pkg::ModeLoadCoord, 0, 0, 32'h8000_0000, '0), 1'b0));
    steps.push_back(item_step(mk(tsne_pkg::ModeLoadCoord, 0, 1, 32'h8000_0000, '0), 1'b0));
    steps.push_back(item_step(mk(tsne_pkg::ModeLoadCoord, 1, 0, 32'h7FFF_FFFF, '0), 1'b0));
    steps.push_back(item_step(mk(tsne_pkg::ModeLoadCoord, 1, 1, 32'h7FFF_FFFF, '0), 1'b0));
    steps.push_back(item_step(mk(tsne_pkg::ModeLoadProb, 0, 1, '0, 16'hFFFF), 1'b0));
    steps.push_back(item_step(mk(tsne_pkg::ModeCompute, 0, 0, '0, '0), 1'b0));
    steps.push_back(item_step(mk(tsne_pkg::ModeLoadCoord, 2, 5, 32'h1234_5678, '0), 1'b0));
    steps.push_back(item_step(mk(tsne_pkg::ModeReserved, 15, 15, 32'hFFFF_FFFF, 16'hFFFF),
                              1'b0));
    steps.push_back(cfg_step(tsne_pkg::CfgNumDims, 5'd0));
    steps.push_back(cfg_step(tsne_pkg::CfgNumPoints, 5'd1));
    steps.push_back(item_step(mk(tsne_pkg::ModeCompute, 0, 0, '0, '0), 1'b0));
    steps.push_back(cfg_step(tsne_pkg::CfgNumPoints, 5'd16));
    steps.push_back(cfg_step(tsne_pkg::CfgNumDims, 5'd7));
    steps.push_back(item_step(mk(tsne_pkg::ModeCompute, 0, 0, '0, '0), 1'b0));
    steps.push_back(cfg_step(tsne_pkg::CfgNumPoints, 5'd31));
    steps.push_back(cfg_step(tsne_pkg::CfgNumDims, 5'd1));
    steps.push_back(item_step(mk(tsne_pkg::ModeCompute, 0, 0, '0, '0), 1'b0));
    foreach (steps[x]) begin
      if (steps[x].is_cfg) write_reg(steps[x].cfg_idx, steps[x].cfg_data);
      else send_item(steps[x].item, steps[x].err_typed, 1'b1);
    end

    for (int ph = 0; ph < 9; ph++) begin
      case ($urandom_range(9))
        0: np_val = 5'd0;
        1: np_val = 5'd1;
        default: np_val = 5'($urandom_range(2, 6));
      endcase
      write_reg(tsne_pkg::CfgNumPoints, np_val);
      write_reg(tsne_pkg::CfgNumDims, 5'($urandom_range(0, 7)));
      for (int it = 0; it < 17; it++)
        send_item(random_item(it == 16 ? 90 : $urandom_range(99)), 1'b0,
                  ph != 3 && ph != 4);
    end

    wait_idle();
    repeat (200) @(negedge clk_i);
    $display("Covered %0d transactions, %0d of them gradient computations,", n_items, n_computes);
    $display("and checked %0d results with %0d mismatches.", n_results, n_errors);
    if (n_errors == 0 && grad_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
